/* design/pidl_pkg.sv */
// ----------------------------------------------------------------------------
// pidl_pkg
// Types and codes shared by the positional insert/delete list.
// ----------------------------------------------------------------------------
package pidl_pkg;

    localparam int WORD_W = 32;
    localparam int POS_W  = 6;

    // request kinds
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_DUMP   = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_POS = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [WORD_W-1:0] value;
        logic [POS_W-1:0]         position;
    } t_request;

    typedef struct packed {
        logic signed [WORD_W-1:0] value_out;
        logic [1:0]               status;
        logic                     last;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request
        logic exec;       // evaluate request, update list
        logic dump_step;  // emit next entry of a dump
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic dump_go;    // request is a dump of a non-empty list
        logic dump_end;   // current dump step emits the final entry
    } t_stat;

endpackage

/* design/positional_insert_delete_list.sv */
// ----------------------------------------------------------------------------
// positional_insert_delete_list
// Ordered list of signed words with one-based insert, delete and dump.
// ----------------------------------------------------------------------------
//  channel   ports                       transfer
//  request   i_start, o_busy, i_req      i_start && !o_busy at clock edge
//  result    o_strobe, o_res             o_strobe high for one cycle
//
//  Insert, delete and invalid requests are captured, then evaluated with
//  every cell shifted at once; the result shows the cycle after evaluation.
//  A dump is captured and evaluated alike, then emits one entry per cycle
//  through the single read mux driven by the dump index.
//  o_busy drops as the last result is registered, so a new request can be
//  taken while that result is on the ports. The receiver cannot stall.
//  Reset is synchronous and empties the list; stored words are not cleared.
// ----------------------------------------------------------------------------
module positional_insert_delete_list #(
    parameter int CAPACITY = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  pidl_pkg::t_request i_req,
    output logic               o_busy,
    output logic               o_strobe,
    output pidl_pkg::t_result  o_res
);
    import pidl_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    pidl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    pidl_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_res    (o_res),
        .o_strobe (o_strobe)
    );

endmodule

/* design/pidl_ctrl.sv */
// ----------------------------------------------------------------------------
// pidl_ctrl
// Sequencer: accept, evaluate, then walk the entries for a dump.
// ----------------------------------------------------------------------------
module pidl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  pidl_pkg::t_stat i_stat,
    output pidl_pkg::t_cmd  o_cmd,
    output logic            o_busy
);
    import pidl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DUMP = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.dump_go ? S_DUMP : S_IDLE;
            end
            S_DUMP: begin
                o_cmd.dump_step = 1'b1;
                if (i_stat.dump_end) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

`ifndef ASSERT_OFF
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !o_busy)
        else $error("request captured while busy");
    a_exec_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.exec)
        else $error("captured request not evaluated");
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(o_cmd) <= 1)
        else $error("overlapping datapath commands");
`endif

endmodule

/* design/pidl_dp.sv */
// ----------------------------------------------------------------------------
// pidl_dp
// Shift-array list storage, entry count, dump index and result register.
// ----------------------------------------------------------------------------
module pidl_dp #(
    parameter int CAPACITY = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pidl_pkg::t_request i_req,
    input  pidl_pkg::t_cmd     i_cmd,
    output pidl_pkg::t_stat    o_stat,
    output pidl_pkg::t_result  o_res,
    output logic               o_strobe
);
    import pidl_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic signed [WORD_W-1:0] r_store [CAPACITY];
    logic signed [WORD_W-1:0] n_store [CAPACITY];
    logic [CW-1:0]            r_count, n_count;
    logic [AW-1:0]            r_idx, n_idx;
    t_request                 r_req;
    t_result                  r_res, n_res;
    logic                     r_strobe, n_strobe;

    logic [XW-1:0]            pos_x, cnt_x;
    logic [POS_W-1:0]         pos_m1;
    logic [AW-1:0]            rd_addr;
    logic signed [WORD_W-1:0] rd_data;
    logic                     dump_last;

    assign pos_x     = XW'(r_req.position);
    assign cnt_x     = XW'(r_count);
    assign pos_m1    = r_req.position - POS_W'(1);
    assign rd_addr   = i_cmd.dump_step ? r_idx : AW'(pos_m1);
    assign rd_data   = r_store[rd_addr];
    assign dump_last = ((CW'(r_idx) + CW'(1)) == r_count);

    assign o_stat.dump_go  = (r_req.kind == KIND_DUMP) && (r_count != '0);
    assign o_stat.dump_end = dump_last;

    always_comb begin
        n_store  = r_store;
        n_count  = r_count;
        n_idx    = r_idx;
        n_res    = r_res;
        n_strobe = 1'b0;
        if (i_cmd.exec) begin
            n_res    = '{value_out: '0, status: ST_BAD_POS, last: 1'b1};
            n_strobe = 1'b1;
            n_idx    = '0;
            case (r_req.kind)
                KIND_INSERT: begin
                    if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
                        n_res.status = ST_BAD_POS;
                    end else if (r_count == CW'(CAPACITY)) begin
                        n_res.status = ST_FULL;
                    end else begin
                        // cells at or after the slot move back one
                        for (int i = 1; i < CAPACITY; i++) begin
                            if (XW'(i) >= pos_x) begin
                                n_store[i] = r_store[i-1];
                            end
                        end
                        for (int i = 0; i < CAPACITY; i++) begin
                            if (XW'(i) + XW'(1) == pos_x) begin
                                n_store[i] = r_req.value;
                            end
                        end
                        n_count      = r_count + CW'(1);
                        n_res.status = ST_OK;
                    end
                end
                KIND_DELETE: begin
                    if (pos_x == '0 || pos_x > cnt_x) begin
                        n_res.status = ST_BAD_POS;
                    end else begin
                        for (int i = 0; i < CAPACITY - 1; i++) begin
                            if (XW'(i) + XW'(1) >= pos_x) begin
                                n_store[i] = r_store[i+1];
                            end
                        end
                        n_count         = r_count - CW'(1);
                        n_res.value_out = rd_data;
                        n_res.status    = ST_OK;
                    end
                end
                KIND_DUMP: begin
                    if (r_count == '0) begin
                        n_res.status = ST_EMPTY;
                    end else begin
                        n_strobe = 1'b0;
                    end
                end
                default: begin
                    n_res.status = ST_BAD_POS;
                end
            endcase
        end else if (i_cmd.dump_step) begin
            n_strobe = 1'b1;
            n_res    = '{value_out: rd_data, status: ST_OK, last: dump_last};
            n_idx    = r_idx + AW'(1);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_store <= n_store;
        r_res   <= n_res;
        r_idx   <= n_idx;
        if (i_cmd.load) begin
            r_req <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    assign o_res    = r_res;
    assign o_strobe = r_strobe;

`ifndef ASSERT_OFF
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && r_res.status != ST_OK |-> r_res.last)
        else $error("error status on a non-final result");
    a_count_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && r_count != $past(r_count) |-> $past(i_cmd.exec))
        else $error("entry count changed outside evaluation");
    a_dump_step_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.dump_step |-> r_count != '0)
        else $error("dump step on empty list");
`endif

endmodule
